// File: hdl/bssd_pkg.sv
package bssd_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_BITS   = 32;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int KEY_W       = WORD_BITS + IDX_W;

  typedef logic [1:0]                  cmd_t;
  typedef logic [1:0]                  status_t;
  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [KEY_W-1:0]            key_t;

  localparam cmd_t CMD_PUSH  = 2'd0;
  localparam cmd_t CMD_POP   = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;
  localparam cmd_t CMD_PRINT = 2'd3;

  localparam status_t STS_OK    = 2'd0;
  localparam status_t STS_FULL  = 2'd1;
  localparam status_t STS_EMPTY = 2'd2;

  // sign flipped so unsigned compare gives signed order; index breaks ties
  function automatic key_t order_key(word_t v, idx_t idx);
    return {~v[WORD_BITS-1], v[WORD_BITS-2:0], idx};
  endfunction

endpackage

// File: hdl/bssd_if.sv
interface bssd_in_if;
  import bssd_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  command;
  word_t push_value;
  modport source(output valid, command, push_value, input ready);
  modport sink(input valid, command, push_value, output ready);
endinterface

interface bssd_out_if;
  import bssd_pkg::*;
  logic    valid;
  logic    ready;
  word_t   read_value;
  status_t status;
  logic    last_of_run;
  modport source(output valid, read_value, status, last_of_run, input ready);
  modport sink(input valid, read_value, status, last_of_run, output ready);
endinterface

// File: hdl/bssd_ram.sv
module bssd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/bounded_stack_sorted_dump.sv
// LIFO stack of signed words held in a single-port-write, single-port-read RAM
// with a registered read port. Push and clear need no RAM read; pop reads the
// top word from the RAM before it is returned. Print with n words stored gives
// n words in ascending signed order, the last one flagged: each output word
// takes one sweep of n RAM reads, after which the sweep is left and the word is
// handed over once the output is free; no further command is taken while a
// print runs. An empty stack answers pop and print with a single empty status.
// No clearing pass after reset; the stack is empty at once.
module bounded_stack_sorted_dump (
  input  logic       clk,
  input  logic       rst_n,
  bssd_in_if.sink    in_ch,
  bssd_out_if.source out_ch
);
  import bssd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  cnt_t       scan_r, scan_nxt;
  cnt_t       emit_cnt_r, emit_cnt_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  idx_t       rd_tag_r, rd_tag_nxt;
  logic       have_prev_r, have_prev_nxt;
  key_t       prev_key_r, prev_key_nxt;
  logic       best_found_r, best_found_nxt;
  key_t       best_key_r, best_key_nxt;
  word_t      best_val_r, best_val_nxt;

  logic       out_vld_r, out_vld_nxt;
  word_t      out_val_r, out_val_nxt;
  status_t    out_sts_r, out_sts_nxt;
  logic       out_last_r, out_last_nxt;

  logic       ram_we, ram_re;
  idx_t       ram_waddr, ram_raddr;
  word_t      ram_rdata;
  logic [WORD_BITS-1:0] ram_rdata_raw;

  logic       out_free, in_acc, out_load;
  cnt_t       cnt_m1;
  key_t       cand_key;

  bssd_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_ch.push_value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata_raw)
  );

  assign ram_rdata    = word_t'(ram_rdata_raw);
  assign out_free     = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cnt_m1       = cnt_r - cnt_t'(1);
  assign cand_key     = order_key(ram_rdata, rd_tag_r);

  assign out_ch.valid       = out_vld_r;
  assign out_ch.read_value  = out_val_r;
  assign out_ch.status      = out_sts_r;
  assign out_ch.last_of_run = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    emit_cnt_nxt   = emit_cnt_r;
    rd_pend_nxt    = 1'b0;
    rd_tag_nxt     = rd_tag_r;
    have_prev_nxt  = have_prev_r;
    prev_key_nxt   = prev_key_r;
    best_found_nxt = best_found_r;
    best_key_nxt   = best_key_r;
    best_val_nxt   = best_val_r;
    out_load       = 1'b0;
    out_val_nxt    = out_val_r;
    out_sts_nxt    = out_sts_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[IDX_W-1:0];
    ram_re         = 1'b0;
    ram_raddr      = scan_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_val_nxt  = '0;
          out_sts_nxt  = STS_OK;
          out_last_nxt = 1'b1;
          unique case (in_ch.command)
            CMD_PUSH: begin
              out_load = 1'b1;
              if (cnt_r == cnt_t'(STACK_DEPTH)) begin
                out_sts_nxt = STS_FULL;
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + cnt_t'(1);
              end
            end
            CMD_POP: begin
              if (cnt_r == '0) begin
                out_load    = 1'b1;
                out_sts_nxt = STS_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[IDX_W-1:0];
                cnt_nxt   = cnt_m1;
                state_nxt = S_POP;
              end
            end
            CMD_CLEAR: begin
              out_load = 1'b1;
              cnt_nxt  = '0;
            end
            CMD_PRINT: begin
              if (cnt_r == '0) begin
                out_load    = 1'b1;
                out_sts_nxt = STS_EMPTY;
              end else begin
                scan_nxt       = '0;
                emit_cnt_nxt   = '0;
                have_prev_nxt  = 1'b0;
                best_found_nxt = 1'b0;
                state_nxt      = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        // output register was free when the pop was taken
        out_load     = 1'b1;
        out_val_nxt  = ram_rdata;
        out_sts_nxt  = STS_OK;
        out_last_nxt = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_SCAN: begin
        if (scan_r != cnt_r) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_tag_nxt  = scan_r[IDX_W-1:0];
          scan_nxt    = scan_r + cnt_t'(1);
        end else if (!rd_pend_r) begin
          state_nxt = S_EMIT;
        end
        // smallest key strictly above the one last emitted
        if (rd_pend_r && (!have_prev_r || cand_key > prev_key_r)
            && (!best_found_r || cand_key < best_key_r)) begin
          best_found_nxt = 1'b1;
          best_key_nxt   = cand_key;
          best_val_nxt   = ram_rdata;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_val_nxt    = best_val_r;
          out_sts_nxt    = STS_OK;
          out_last_nxt   = (emit_cnt_r + cnt_t'(1)) == cnt_r;
          emit_cnt_nxt   = emit_cnt_r + cnt_t'(1);
          have_prev_nxt  = 1'b1;
          prev_key_nxt   = best_key_r;
          best_found_nxt = 1'b0;
          scan_nxt       = '0;
          state_nxt      = ((emit_cnt_r + cnt_t'(1)) == cnt_r) ? S_IDLE : S_SCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_vld_nxt = out_load ? 1'b1 : (out_vld_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_vld_r    <= 1'b0;
      rd_pend_r    <= 1'b0;
      have_prev_r  <= 1'b0;
      best_found_r <= 1'b0;
      scan_r       <= '0;
      emit_cnt_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_vld_r    <= out_vld_nxt;
      rd_pend_r    <= rd_pend_nxt;
      have_prev_r  <= have_prev_nxt;
      best_found_r <= best_found_nxt;
      scan_r       <= scan_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r   <= rd_tag_nxt;
    prev_key_r <= prev_key_nxt;
    best_key_r <= best_key_nxt;
    best_val_r <= best_val_nxt;
    if (out_load) begin
      out_val_r  <= out_val_nxt;
      out_sts_r  <= out_sts_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(STACK_DEPTH))
    else $error("entry count beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_vld_r || out_ch.ready))
    else $error("pending word overwritten");

  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> best_found_r)
    else $error("no word found for print step");

  a_print_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_EMIT) |=> $stable(cnt_r))
    else $error("print altered the stack");

  a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_EMIT) |-> (emit_cnt_r < cnt_r))
    else $error("print ran past stored words");

endmodule
